[rtl/woi_pkg.sv]
`timescale 1ns / 1ps
// Package for the wheel odometry integrator.
// Holds the sequencer state type, the CORDIC arctangent table and fixed constants.
// No dependencies.
package woi_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FS,
		ST_CINIT,
		ST_CITER,
		ST_CFIN,
		ST_VMUL,
		ST_PMUL,
		ST_DIVQ,
		ST_DIVR,
		ST_POS,
		ST_HMUL1,
		ST_HMUL2,
		ST_HMUL3,
		ST_OUT
	} st_t;

	localparam int MUL_W = 34;
	localparam int CRD_W = 34;
	localparam int ATAN_IW = 5;
	localparam int DIV_W = 45;
	localparam int DCNT_W = 2;
	localparam int DIV_DIGITS = 4;
	localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(DIV_DIGITS - 1);
	// divide by 10^6 as a shift by 6, then 16-bit digits divided by 15625
	localparam int DIV_RSH = 44;
	localparam logic [30:0] DIV_RECIP = 31'd1125899907;
	localparam logic [13:0] DIV_BASE = 14'd15625;

	localparam logic [31:0] SCALE_RESET = 32'd107944296;
	localparam logic [29:0] HEADING_GAIN = 30'd716770142;
	localparam logic signed [CRD_W-1:0] CORDIC_GAIN = 34'sd652032875;
	localparam logic [20:0] USEC_PER_SEC = 21'd1000000;

	localparam logic [29:0] ATAN_TAB [0:31] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
		30'd42667331, 30'd21354465, 30'd10679838, 30'd5340245,
		30'd2670163, 30'd1335087, 30'd667544, 30'd333772,
		30'd166886, 30'd83443, 30'd41722, 30'd20861,
		30'd10430, 30'd5215, 30'd2608, 30'd1304,
		30'd652, 30'd326, 30'd163, 30'd81,
		30'd41, 30'd20, 30'd10, 30'd5,
		30'd3, 30'd1, 30'd1, 30'd0
	};

endpackage

[rtl/wheel_odometry_integrator_top.sv]
`timescale 1ns / 1ps
// Wheel odometry integrator: fixed-point dead reckoning with one shared
// multiplier, a CORDIC iterator and a reciprocal-multiply divider. Depends on woi_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one item per transfer: kind 1 is a
//   gyro sample that stores yaw_rate_in, kind 0 is a wheel sample that updates the
//   forward speed and, once a previous time is known and time advanced, the pose.
//   Output channel (out_valid / out_stall) carries one pose per integrating wheel
//   item; gyro items and non-integrating wheel items give no transfer.
//   cfg_we / cfg_data write speed_scale (Q0.32); write only while idle.
//   Steps per item: a gyro item is taken in idle, a wheel item without a result
//   passes the speed step and goes back to idle, and an integrating wheel item
//   runs two CORDIC passes of CORDIC_STEPS iterations and two divisions by 10^6
//   in four 16-bit digits of two multiplies each, all sequenced over one 34x34
//   multiplier.
//   in_stall is high from the transfer until the sequencer is back in idle.
//   The pose sits in an output register; while out_stall holds it, the next item
//   is taken and worked on, and its pose waits in the last step until the
//   register is free.
//   Reset clears the pose, speed, rate, time state and sets speed_scale to its
//   default; no output is valid after reset.
module wheel_odometry_integrator_top #(
	parameter int CORDIC_STEPS = 16,
	parameter int DT_CLAMP_BITS = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                kind,
	input  logic signed [15:0]  left_speed,
	input  logic signed [15:0]  right_speed,
	input  logic signed [15:0]  yaw_rate_in,
	input  logic [47:0]         time_us,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  pos_x,
	output logic signed [31:0]  pos_y,
	output logic signed [15:0]  heading,
	output logic signed [15:0]  quat_z,
	output logic [14:0]         quat_w,
	output logic [47:0]         stamp_us,
	input  logic                cfg_we,
	input  logic [31:0]         cfg_data
);
	import woi_pkg::*;

	localparam int DT_W = DT_CLAMP_BITS + 1;
	localparam logic [ATAN_IW-1:0] CITER_LAST = ATAN_IW'(CORDIC_STEPS - 1);
	localparam logic [47:0] DT_LIMIT = 48'(1) << DT_CLAMP_BITS;

	st_t state_q, state_d;

	logic [31:0]              scale_q;
	logic                     seen_q;
	logic [47:0]              last_q;
	logic signed [31:0]       fs_q;
	logic signed [15:0]       rate_q;
	logic signed [31:0]       x_q;
	logic signed [31:0]       y_q;
	logic signed [15:0]       head_q;
	logic                     out_valid_q;

	logic [47:0]              now_q;
	logic signed [16:0]       sum_q;
	logic [DT_W-1:0]          dt_q;
	logic                     pass_q;
	logic                     axis_q;
	logic signed [CRD_W-1:0]  cx_q, cy_q, cz_q;
	logic                     flip_q;
	logic [ATAN_IW-1:0]       citer_q;
	logic signed [16:0]       c_q, s_q;
	logic signed [31:0]       part_q;
	logic                     neg_q;
	logic [13:0]              rem_q;
	logic [63:0]              dd_q;
	logic [DIV_W-1:0]         quo_q;
	logic [DCNT_W-1:0]        dcnt_q;
	logic [63:0]              p_q;
	logic [61:0]              a_q;

	logic signed [MUL_W-1:0]   mul_a, mul_b;
	logic signed [2*MUL_W-1:0] mul_p;

	logic [47:0]              diff;
	logic                     dt_pos;
	logic signed [31:0]       ang;
	logic signed [CRD_W-1:0]  z0;
	logic signed [CRD_W-1:0]  sx, sy, at;
	logic signed [18:0]       xr, yr;
	logic signed [16:0]       c_new, s_new;
	logic signed [2*MUL_W-1:0] fs_full, v_full, p_neg;
	logic signed [31:0]       part_new;
	logic [63:0]              mag;
	logic [29:0]              div_v;
	logic signed [DIV_W:0]    step;
	logic signed [DIV_W+1:0]  pos_sum;
	logic signed [31:0]       pos_new;
	logic [63:0]              hsum;

	assign mul_p = mul_a * mul_b;

	assign diff = now_q - last_q;
	assign dt_pos = now_q > last_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && !kind) begin
					state_d = ST_FS;
				end
			end
			ST_FS: begin
				if (seen_q && dt_pos) begin
					state_d = ST_CINIT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_CINIT: state_d = ST_CITER;
			ST_CITER: begin
				if (citer_q == CITER_LAST) begin
					state_d = ST_CFIN;
				end
			end
			ST_CFIN: state_d = pass_q ? ST_OUT : ST_VMUL;
			ST_VMUL: state_d = ST_PMUL;
			ST_PMUL: state_d = ST_DIVQ;
			ST_DIVQ: state_d = ST_DIVR;
			ST_DIVR: begin
				if (dcnt_q == DIV_LAST) begin
					state_d = ST_POS;
				end else begin
					state_d = ST_DIVQ;
				end
			end
			ST_POS: state_d = axis_q ? ST_HMUL1 : ST_VMUL;
			ST_HMUL1: state_d = ST_HMUL2;
			ST_HMUL2: state_d = ST_HMUL3;
			ST_HMUL3: state_d = ST_CINIT;
			ST_OUT: begin
				if (!(out_valid_q && out_stall)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer: handshake and multiplier operands
	always_comb begin
		in_stall = (state_q != ST_IDLE);
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_FS: begin
				mul_a = MUL_W'(sum_q);
				mul_b = $signed(MUL_W'(scale_q));
			end
			ST_VMUL: begin
				mul_a = MUL_W'(fs_q);
				mul_b = axis_q ? MUL_W'(s_q) : MUL_W'(c_q);
			end
			ST_PMUL: begin
				mul_a = MUL_W'(part_q);
				mul_b = MUL_W'($signed({1'b0, dt_q}));
			end
			ST_DIVQ: begin
				mul_a = MUL_W'(div_v);
				mul_b = MUL_W'(DIV_RECIP);
			end
			ST_DIVR: begin
				mul_a = MUL_W'(quo_q[15:0]);
				mul_b = MUL_W'(DIV_BASE);
			end
			ST_HMUL1: begin
				mul_a = MUL_W'(rate_q);
				mul_b = MUL_W'($signed({1'b0, dt_q}));
			end
			ST_HMUL2: begin
				mul_a = $signed(MUL_W'(p_q[31:0]));
				mul_b = $signed(MUL_W'(HEADING_GAIN));
			end
			ST_HMUL3: begin
				mul_a = MUL_W'($signed(p_q[63:32]));
				mul_b = $signed(MUL_W'(HEADING_GAIN));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		ang = pass_q ? 32'($signed({head_q, 15'd0})) : $signed({head_q, 16'd0});
		z0 = CRD_W'(ang);
		sx = cx_q >>> citer_q;
		sy = cy_q >>> citer_q;
		at = $signed(CRD_W'(ATAN_TAB[citer_q]));

		xr = 19'((flip_q ? -cx_q : cx_q) + 34'sd16384 >>> 15);
		yr = 19'((flip_q ? -cy_q : cy_q) + 34'sd16384 >>> 15);
		if (xr > 19'sd32768) begin
			c_new = 17'sd32768;
		end else if (xr < -19'sd32768) begin
			c_new = -17'sd32768;
		end else begin
			c_new = 17'(xr);
		end
		if (yr > 19'sd32768) begin
			s_new = 17'sd32768;
		end else if (yr < -19'sd32768) begin
			s_new = -17'sd32768;
		end else begin
			s_new = 17'(yr);
		end

		fs_full = (mul_p + 68'sd65536) >>> 17;
		v_full = mul_p >>> 15;
		if (v_full > 68'sd2147483647) begin
			part_new = 32'sh7fffffff;
		end else if (v_full < -68'sd2147483648) begin
			part_new = 32'sh80000000;
		end else begin
			part_new = 32'(v_full);
		end
		p_neg = -mul_p;
		mag = mul_p[2*MUL_W-1] ? p_neg[63:0] : mul_p[63:0];

		div_v = {rem_q, dd_q[63:48]};

		step = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
		pos_sum = (DIV_W+2)'(axis_q ? y_q : x_q) + (DIV_W+2)'(step);
		if (pos_sum > (DIV_W+2)'(32'sh7fffffff)) begin
			pos_new = 32'sh7fffffff;
		end else if (pos_sum < (DIV_W+2)'(32'sh80000000)) begin
			pos_new = 32'sh80000000;
		end else begin
			pos_new = 32'(pos_sum);
		end

		hsum = {2'b00, a_q} + {mul_p[31:0], 32'd0};
	end

	// control and model state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			scale_q <= SCALE_RESET;
			seen_q <= 1'b0;
			last_q <= '0;
			fs_q <= '0;
			rate_q <= '0;
			x_q <= '0;
			y_q <= '0;
			head_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				scale_q <= cfg_data;
			end
			if (state_q == ST_OUT && !(out_valid_q && out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && kind) begin
						rate_q <= yaw_rate_in;
					end
				end
				ST_FS: begin
					fs_q <= 32'(fs_full);
					if (!seen_q) begin
						seen_q <= 1'b1;
						last_q <= now_q;
					end
				end
				ST_POS: begin
					if (axis_q) begin
						y_q <= pos_new;
					end else begin
						x_q <= pos_new;
					end
				end
				ST_HMUL3: begin
					head_q <= head_q + $signed(hsum[63:48]);
					last_q <= now_q;
				end
				default: begin
				end
			endcase
		end
	end

	// working registers of the sequencer
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				now_q <= time_us;
				sum_q <= 17'(left_speed) + 17'(right_speed);
				pass_q <= 1'b0;
			end
			ST_FS: begin
				dt_q <= (diff > DT_LIMIT) ? DT_W'(DT_LIMIT) : DT_W'(diff);
			end
			ST_CINIT: begin
				cx_q <= CORDIC_GAIN;
				cy_q <= '0;
				citer_q <= '0;
				if (z0 > 34'sd1073741824) begin
					cz_q <= z0 - 34'sd2147483648;
					flip_q <= 1'b1;
				end else if (z0 < -34'sd1073741824) begin
					cz_q <= z0 + 34'sd2147483648;
					flip_q <= 1'b1;
				end else begin
					cz_q <= z0;
					flip_q <= 1'b0;
				end
			end
			ST_CITER: begin
				if (cz_q >= 0) begin
					cx_q <= cx_q - sy;
					cy_q <= cy_q + sx;
					cz_q <= cz_q - at;
				end else begin
					cx_q <= cx_q + sy;
					cy_q <= cy_q - sx;
					cz_q <= cz_q + at;
				end
				citer_q <= citer_q + 1'b1;
			end
			ST_CFIN: begin
				c_q <= c_new;
				s_q <= s_new;
				axis_q <= 1'b0;
			end
			ST_VMUL: part_q <= part_new;
			ST_PMUL: begin
				neg_q <= mul_p[2*MUL_W-1];
				rem_q <= '0;
				dd_q <= {6'd0, mag[63:6]};
				quo_q <= '0;
				dcnt_q <= '0;
			end
			ST_DIVQ: quo_q <= {quo_q[DIV_W-17:0], mul_p[DIV_RSH+15:DIV_RSH]};
			ST_DIVR: begin
				rem_q <= 14'(div_v - mul_p[29:0]);
				dd_q <= {dd_q[47:0], 16'd0};
				dcnt_q <= dcnt_q + 1'b1;
			end
			ST_POS: axis_q <= 1'b1;
			ST_HMUL1: p_q <= mul_p[63:0];
			ST_HMUL2: a_q <= mul_p[61:0];
			ST_HMUL3: pass_q <= 1'b1;
			ST_OUT: begin
				if (!(out_valid_q && out_stall)) begin
					pos_x <= x_q;
					pos_y <= y_q;
					heading <= head_q;
					quat_z <= (s_q > 17'sd32767) ? 16'sh7fff : 16'(s_q);
					quat_w <= (c_q < 0) ? 15'd0 :
						((c_q > 17'sd32767) ? 15'h7fff : 15'(c_q));
					stamp_us <= now_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;

	a_citer_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CITER |-> citer_q <= CITER_LAST)
		else $error("CORDIC iteration count past its last step");

	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVQ || state_q == ST_DIVR) |-> rem_q < DIV_BASE)
		else $error("divider remainder out of range");

	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_OUT)
		else $error("output became valid outside the output step");

	a_out_pose: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> heading == head_q && pos_x == x_q && pos_y == y_q)
		else $error("emitted pose differs from integrator state");

	a_busy_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !kind |=> state_q == ST_FS)
		else $error("wheel transfer did not start the sequencer");

endmodule
